/* rtl/nfcm_pkg.sv */
// Package for the nearest free count matcher.
// Holds widths, action codes and the types shared by the matcher modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nfcm_pkg;

  // Keyword table size and derived index width
  localparam int NUM_KEYWORDS = 1024;
  localparam int KW_IDX_W     = $clog2(NUM_KEYWORDS);

  // Field widths
  localparam int ACT_W  = 2;
  localparam int IDX_W  = 10;
  localparam int REF_W  = 20;
  localparam int OBS_W  = 24;
  localparam int PAD_W  = 20;
  localparam int DIST_W = 25;
  // Signed width of obs - pad - 2*ref
  localparam int ADJ_W  = 27;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Item action codes
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_CLEAR = 2'd1,
    ACT_MATCH = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  // Scan control, aligned with the keyword store read data
  typedef struct packed {
    logic                clr;
    logic                valid;
    logic [KW_IDX_W-1:0] idx;
  } scan_ctl_t;

  // Running best candidate
  typedef struct packed {
    logic                have;
    logic [KW_IDX_W-1:0] idx;
    logic [DIST_W-1:0]   distance;
  } best_t;

endpackage
`default_nettype wire

/* rtl/nfcm_keyword_store.sv */
// Keyword store: reference count memory and taken-flag memory.
// One write port and one registered read port each. Uses nfcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfcm_keyword_store (
  input  wire logic                         clk_i,
  input  wire logic                         ref_we_i,
  input  wire logic [nfcm_pkg::KW_IDX_W-1:0] ref_waddr_i,
  input  wire logic [nfcm_pkg::REF_W-1:0]    ref_wdata_i,
  input  wire logic                         tk_we_i,
  input  wire logic [nfcm_pkg::KW_IDX_W-1:0] tk_waddr_i,
  input  wire logic                         tk_wdata_i,
  input  wire logic [nfcm_pkg::KW_IDX_W-1:0] raddr_i,
  output logic      [nfcm_pkg::REF_W-1:0]    ref_rdata_o,
  output logic                              tk_rdata_o
);
  import nfcm_pkg::*;

  logic [REF_W-1:0] ref_mem [NUM_KEYWORDS];
  logic             tk_mem  [NUM_KEYWORDS];

  // Reference counts
  always_ff @(posedge clk_i) begin
    if (ref_we_i) begin
      ref_mem[ref_waddr_i] <= ref_wdata_i;
    end
    ref_rdata_o <= ref_mem[raddr_i];
  end

  // Taken flags
  always_ff @(posedge clk_i) begin
    if (tk_we_i) begin
      tk_mem[tk_waddr_i] <= tk_wdata_i;
    end
    tk_rdata_o <= tk_mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/nfcm_dist_unit.sv */
// Shared distance and compare unit: one keyword per cycle.
// Stage 1 forms the saturated |adj - 2*ref|, stage 2 keeps the lowest. Uses nfcm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nfcm_dist_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire nfcm_pkg::scan_ctl_t            ctl_i,
  input  wire logic signed [nfcm_pkg::ADJ_W-1:0] adj_i,
  input  wire logic        [nfcm_pkg::REF_W-1:0] ref_i,
  input  wire logic                           taken_i,
  output nfcm_pkg::best_t                     best_o
);
  import nfcm_pkg::*;

  logic signed [ADJ_W-1:0] diff;
  logic        [ADJ_W-1:0] mag;
  logic        [DIST_W-1:0] dist_sat;

  logic                s1_v_q;
  logic [KW_IDX_W-1:0] s1_idx_q;
  logic [DIST_W-1:0]   s1_dist_q;
  best_t               best_q, best_d;

  // Distance with saturation
  always_comb begin
    diff     = adj_i - $signed({{(ADJ_W-REF_W-1){1'b0}}, ref_i, 1'b0});
    mag      = diff[ADJ_W-1] ? ADJ_W'(-diff) : ADJ_W'(diff);
    dist_sat = (mag > ADJ_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(mag);
  end

  // Stage 1: free keywords only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else begin
      s1_v_q <= ctl_i.valid & ~taken_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q  <= ctl_i.idx;
    s1_dist_q <= dist_sat;
  end

  // Stage 2: strict less-than keeps the lowest index on ties
  always_comb begin
    best_d = best_q;
    if (ctl_i.clr) begin
      best_d.have     = 1'b0;
      best_d.idx      = '0;
      best_d.distance = '0;
    end else if (s1_v_q && (!best_q.have || s1_dist_q < best_q.distance)) begin
      best_d.have     = 1'b1;
      best_d.idx      = s1_idx_q;
      best_d.distance = s1_dist_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q <= '0;
    end else begin
      best_q <= best_d;
    end
  end

  assign best_o = best_q;

endmodule
`default_nettype wire

/* rtl/nearest_free_count_matcher.sv */
// Nearest free count matcher, top level: sequencer, padding register, result register.
// A match item scans all NUM_KEYWORDS entries at one per cycle through the store read port,
// then drains the read and distance stages and marks the winning keyword, if any, as taken,
// with busy high throughout; the result is strobed in the next cycle, as busy drops.
// A clear item holds busy while it sweeps the taken flags to zero; load items raise no busy.
// After reset the taken flags are swept to zero with busy high.
// Results are strobed for one cycle; the receiver cannot stall. Uses nfcm_pkg and submodules.
`timescale 1ns / 1ps
`default_nettype none
module nearest_free_count_matcher (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Item channel
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [nfcm_pkg::ACT_W-1:0]   action_i,
  input  wire logic [nfcm_pkg::IDX_W-1:0]   ref_index_i,
  input  wire logic [nfcm_pkg::REF_W-1:0]   ref_count_i,
  input  wire logic [nfcm_pkg::OBS_W-1:0]   obs_count_i,
  // Configuration: padding offset
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [nfcm_pkg::PAD_W-1:0]   cfg_data_i,
  // Results
  output logic                              result_valid_o,
  output logic      [nfcm_pkg::IDX_W-1:0]   match_index_o,
  output logic                              found_o,
  output logic      [nfcm_pkg::DIST_W-1:0]  distance_o
);
  import nfcm_pkg::*;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_MARK  = 3'd4;

  localparam logic [KW_IDX_W-1:0] LAST_IDX = KW_IDX_W'(NUM_KEYWORDS - 1);

  logic [2:0]          state_q, state_d;
  logic [KW_IDX_W-1:0] cnt_q, cnt_d;
  logic                drain_q, drain_d;
  logic [PAD_W-1:0]    pad_q;
  logic signed [ADJ_W-1:0] adj_q;
  scan_ctl_t           ctl_q, ctl_d;
  best_t               best;

  logic                accept;
  action_e             act;
  logic                ref_we;
  logic                tk_we;
  logic [KW_IDX_W-1:0] tk_waddr;
  logic                tk_wdata;
  logic [REF_W-1:0]    ref_rdata;
  logic                tk_rdata;

  logic                res_v_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic                res_found_q;
  logic [DIST_W-1:0]   res_dist_q;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start & ~busy;
  assign act         = action_e'(action_i);
  assign cfg_ready_o = 1'b1;

  // Padding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pad_q <= cfg_data_i;
    end
  end

  // Observed count minus padding, taken once per match item
  always_ff @(posedge clk_i) begin
    if (accept && act == ACT_MATCH) begin
      adj_q <= $signed({{(ADJ_W-OBS_W){1'b0}}, obs_count_i})
             - $signed({{(ADJ_W-PAD_W){1'b0}}, pad_q});
    end
  end

  // Load writes go straight to the store; out-of-range slots dropped
  assign ref_we = accept && (act == ACT_LOAD) && (32'(ref_index_i) < NUM_KEYWORDS);

  // Taken flag write: clearing sweep or marking the winner
  always_comb begin
    tk_we    = 1'b0;
    tk_waddr = cnt_q;
    tk_wdata = 1'b0;
    if (state_q == ST_SWEEP) begin
      tk_we = 1'b1;
    end else if (state_q == ST_MARK && best.have) begin
      tk_we    = 1'b1;
      tk_waddr = best.idx;
      tk_wdata = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    drain_d   = drain_q;
    ctl_d     = '0;
    case (state_q)
      ST_SWEEP: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_d = '0;
        if (accept) begin
          case (act)
            ACT_CLEAR: state_d = ST_SWEEP;
            ACT_MATCH: begin
              state_d   = ST_SCAN;
              ctl_d.clr = 1'b1;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        ctl_d.valid = 1'b1;
        ctl_d.idx   = cnt_q;
        cnt_d       = cnt_q + 1'b1;
        if (cnt_q == LAST_IDX) begin
          state_d = ST_DRAIN;
          drain_d = 1'b0;
        end
      end
      ST_DRAIN: begin
        // read and distance stages empty out
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = ST_MARK;
        end
      end
      ST_MARK: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SWEEP;
      cnt_q   <= '0;
      drain_q <= 1'b0;
      ctl_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drain_q <= drain_d;
      ctl_q   <= ctl_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= (state_q == ST_MARK);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_MARK) begin
      res_idx_q   <= IDX_W'(best.idx);
      res_found_q <= best.have;
      res_dist_q  <= best.distance;
    end
  end

  assign result_valid_o = res_v_q;
  assign match_index_o  = res_idx_q;
  assign found_o        = res_found_q;
  assign distance_o     = res_dist_q;

  nfcm_keyword_store u_store (
    .clk_i       (clk_i),
    .ref_we_i    (ref_we),
    .ref_waddr_i (KW_IDX_W'(ref_index_i)),
    .ref_wdata_i (ref_count_i),
    .tk_we_i     (tk_we),
    .tk_waddr_i  (tk_waddr),
    .tk_wdata_i  (tk_wdata),
    .raddr_i     (cnt_q),
    .ref_rdata_o (ref_rdata),
    .tk_rdata_o  (tk_rdata)
  );

  nfcm_dist_unit u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl_q),
    .adj_i   (adj_q),
    .ref_i   (ref_rdata),
    .taken_i (tk_rdata),
    .best_o  (best)
  );

endmodule
`default_nettype wire
